FILE: rtl/uri_percent_decoder_top_assert.svh
// Assertion macros shared by the percent decoder modules.
`ifndef URI_PERCENT_DECODER_TOP_ASSERT_SVH
`define URI_PERCENT_DECODER_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked while out of reset.
`define UPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("upd assertion failed");
// Checked on every edge, reset included.
`define UPD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("upd assertion failed");
`else
`define UPD_ASSERT(lbl, prop)
`define UPD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/upd_pkg.sv
// Shared types, constants and helpers of the URI percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int MAX_RESULTS     = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  // word index of the plus_always_space register
  localparam logic REG_PLUS_ALWAYS = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  // results of one input item
  typedef struct packed {
    logic [1:0]                  cnt;
    logic                        last;
    logic [MAX_RESULTS-1:0][7:0] bytes;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } qwr_t;

  typedef struct packed {
    logic    full;
    logic    empty;
    bundle_t head;
  } qstat_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // only meaningful when is_hex(b)
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    if (b <= 8'h39) begin
      v = b[3:0];
    end else begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

FILE: rtl/uri_percent_decoder_top.sv
// An item's first result passes through the bundle queue, then the output register.
// Throughput: one item per cycle while items yield at most one byte each and out_stall
// is low; the output register drains one byte per cycle, an item's bytes in order.
// The bundle queue (QUEUE_DEPTH entries) stalls the input only when it fills.
// Reset (rst_n low, synchronous): no escape pending, query flag clear, queue and output
// empty, plus_always_space = 1. No clearing pass is needed.
module uri_percent_decoder_top #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF  // 2..16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Config register: '+' becomes a space everywhere when set.
  logic plus_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_r <= 1'b1;
    end else if (cfg_wr && paddr[2] == upd_pkg::REG_PLUS_ALWAYS) begin
      plus_r <= pwdata[0];
    end
  end

  // paddr[1:0] is the byte offset within the word, ignored
  always_comb begin
    prdata = '0;
    if (paddr[2] == upd_pkg::REG_PLUS_ALWAYS) begin
      prdata[0] = plus_r;
    end
  end

  upd_pkg::qwr_t   qw;
  upd_pkg::qstat_t qs;
  logic            pop;

  // Front: classifies each byte and emits a bundle of 0..3 result bytes.
  upd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .plus_always_space (plus_r),
    .qs                (qs),
    .qw                (qw)
  );

  // Queue decouples input stalls from output stalls.
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qw    (qw),
    .pop   (pop),
    .qs    (qs)
  );

  // Back: serializes bundles into single output items.
  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qs        (qs),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: rtl/upd_front.sv
// Front end: accepts raw bytes, tracks escape and query state, builds result bundles.
`include "uri_percent_decoder_top_assert.svh"
module upd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            plus_always_space,
  input  upd_pkg::qstat_t qs,
  output upd_pkg::qwr_t   qw
);

  upd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;
  logic            query_r, query_nxt;

  logic [upd_pkg::MAX_RESULTS-1:0][7:0] em;
  logic [1:0]      n;
  logic            do_plain;
  logic            hex;
  logic            acc;

  assign in_stall = qs.full;
  assign acc      = in_valid && !qs.full;
  assign hex      = upd_pkg::is_hex(in_byte);

  always_comb begin
    em        = '0;
    n         = 2'd0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    query_nxt = query_r;
    do_plain  = 1'b0;
    case (phase_r)
      upd_pkg::PH_PCT: begin
        if (hex) begin
          held_nxt  = in_byte;
          phase_nxt = upd_pkg::PH_DIG;
        end else begin
          em[0]     = upd_pkg::CH_PERCENT;
          n         = 2'd1;
          phase_nxt = upd_pkg::PH_IDLE;
          do_plain  = 1'b1;
        end
      end
      upd_pkg::PH_DIG: begin
        if (hex) begin
          em[0]     = {upd_pkg::hex_val(held_r), upd_pkg::hex_val(in_byte)};
          n         = 2'd1;
          phase_nxt = upd_pkg::PH_IDLE;
          held_nxt  = '0;
        end else begin
          // failed escape: '%' and the held digit go out literally
          em[0]     = upd_pkg::CH_PERCENT;
          em[1]     = held_r;
          n         = 2'd2;
          phase_nxt = upd_pkg::PH_IDLE;
          held_nxt  = '0;
          do_plain  = 1'b1;
        end
      end
      default: begin
        phase_nxt = upd_pkg::PH_IDLE;
        do_plain  = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (in_byte == upd_pkg::CH_PERCENT) begin
        phase_nxt = upd_pkg::PH_PCT;
      end else begin
        if (in_byte == upd_pkg::CH_QUERY) begin
          query_nxt = 1'b1;
        end
        if (in_byte == upd_pkg::CH_PLUS && (query_r || plus_always_space)) begin
          em[n] = upd_pkg::CH_SPACE;
        end else begin
          em[n] = in_byte;
        end
        n = n + 2'd1;
      end
    end

    // end of URI: flush pending escape bytes, clear state
    if (in_last) begin
      case (phase_nxt)
        upd_pkg::PH_PCT: begin
          em[n] = upd_pkg::CH_PERCENT;
          n     = n + 2'd1;
        end
        upd_pkg::PH_DIG: begin
          em[n]         = upd_pkg::CH_PERCENT;
          em[n + 2'd1]  = held_nxt;
          n             = n + 2'd2;
        end
        default: ;
      endcase
      phase_nxt = upd_pkg::PH_IDLE;
      held_nxt  = '0;
      query_nxt = 1'b0;
    end
  end

  assign qw.push       = acc && (n != 2'd0);
  assign qw.data.cnt   = n;
  assign qw.data.last  = in_last;
  assign qw.data.bytes = em;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_IDLE;
      held_r  <= '0;
      query_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      query_r <= query_nxt;
    end
  end

  `UPD_ASSERT(a_last_clears, acc && in_last |=> phase_r == upd_pkg::PH_IDLE && !query_r)
  `UPD_ASSERT(a_last_pushes, acc && in_last |-> qw.push && qw.data.last)

endmodule

FILE: rtl/upd_queue.sv
// Small bundle queue between the front end and the output serializer.
`include "uri_percent_decoder_top_assert.svh"
module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  upd_pkg::qwr_t   qw,
  input  logic            pop,
  output upd_pkg::qstat_t qs
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  upd_pkg::bundle_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    fill_r;

  assign qs.full  = (fill_r == CW'(DEPTH));
  assign qs.empty = (fill_r == '0);
  assign qs.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (qw.push) begin
      mem_r[wr_ptr_r] <= qw.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (qw.push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({qw.push, pop})
        2'b10:   fill_r <= fill_r + CW'(1);
        2'b01:   fill_r <= fill_r - CW'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

  `UPD_ASSERT(a_no_overflow, qw.push |-> !qs.full)
  `UPD_ASSERT(a_no_underflow, pop |-> !qs.empty)

endmodule

FILE: rtl/upd_back.sv
// Back end: walks each bundle one byte at a time into the output register.
`include "uri_percent_decoder_top_assert.svh"
module upd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  upd_pkg::qstat_t qs,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic [1:0] sel_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       load;
  logic       last_of;

  assign load    = !qs.empty && (!out_valid_r || !out_stall);
  assign last_of = (sel_r == 2'(qs.head.cnt - 2'd1));
  assign pop     = load && last_of;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        sel_r       <= last_of ? 2'd0 : sel_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= qs.head.bytes[sel_r];
      out_last_r <= qs.head.last && last_of;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `UPD_ASSERT(a_sel_in_range, !qs.empty |-> sel_r < qs.head.cnt)

endmodule
